>>> design/mrsm_pkg.sv
`timescale 1ns / 1ps
package mrsm_pkg;

  // reply buffer depth and derived widths
  localparam int RX_BUFFER_BYTES = 32;
  localparam int RX_AW = $clog2(RX_BUFFER_BYTES);
  localparam int RX_CW = $clog2(RX_BUFFER_BYTES + 1);

  // input command codes
  localparam logic [1:0] CMD_START_READ  = 2'd0;
  localparam logic [1:0] CMD_START_WRITE = 2'd1;
  localparam logic [1:0] CMD_RX_BYTE     = 2'd2;
  localparam logic [1:0] CMD_TICK        = 2'd3;

  // frame constants
  localparam logic [7:0]  FUNC_READ  = 8'h03;
  localparam logic [7:0]  FUNC_WRITE = 8'h06;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  READ_MIN_LEN  = 8'd7;
  localparam logic [7:0]  WRITE_MIN_LEN = 8'd8;

  // register map
  localparam int APB_AW = 5;
  localparam logic [2:0] REG_SLAVE_ADDR  = 3'd0;
  localparam logic [2:0] REG_READ_TMO    = 3'd1;
  localparam logic [2:0] REG_WRITE_TMO   = 3'd2;
  localparam logic [2:0] REG_RETRY       = 3'd3;
  localparam logic [2:0] REG_FRAME_GAP   = 3'd4;
  localparam logic [2:0] REG_READ_PAUSE  = 3'd5;
  localparam logic [2:0] REG_WRITE_PAUSE = 3'd6;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [15:0] read_timeout_ticks;
    logic [15:0] write_timeout_ticks;
    logic [7:0]  retry_count;
    logic [7:0]  frame_gap_ticks;
    logic [7:0]  read_pause_ticks;
    logic [7:0]  write_pause_ticks;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic start_load;
    logic send_init;
    logic send_step;
    logic rx_open;
    logic byte_store;
    logic tick_rx;
    logic pause_begin;
    logic pause_dec;
    logic attempt_dec;
    logic chk_start;
    logic chk_step;
    logic emit_fin;
    logic fin_fail;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] command;
    logic       count_lt_n;
    logic       count_last;
    logic       rx_end;
    logic       pause_zero;
    logic       attempts_zero;
    logic       limit_zero;
    logic       send_last;
    logic       short_reply;
    logic       chk_done;
    logic       reply_ok;
    logic       out_free;
  } dp_sts_t;

  // one byte through the reflected crc-16
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> design/mrsm_if.sv
`timescale 1ns / 1ps
interface mrsm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] register_address;
  logic [15:0] write_value;
  logic [7:0]  received_byte;
  modport source (output valid, command, register_address, write_value, received_byte,
                  input ready);
  modport sink (input valid, command, register_address, write_value, received_byte,
                output ready);
endinterface

interface mrsm_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  transmit_byte;
  logic        last_of_run;
  logic        status;
  logic [15:0] read_data;
  modport source (output valid, result_kind, transmit_byte, last_of_run, status, read_data,
                  input ready);
  modport sink (input valid, result_kind, transmit_byte, last_of_run, status, read_data,
                output ready);
endinterface

>>> design/modbus_rtu_single_register_master_top.sv
`timescale 1ns / 1ps
// a start is accepted and evaluated, then the request goes out at one byte per cycle
// while the output is taken; a received byte or tick is accepted, then evaluated
// a completed reply is read back from the buffer ram, one byte per cycle
// one item at a time; the buffer ram read port and the crc unit set the check time
// reset (async, active low): registers to defaults, idle, no result pending
module modbus_rtu_single_register_master_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mrsm_in_if.sink                      in_if,
  mrsm_out_if.source                   out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mrsm_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import mrsm_pkg::*;

  cfg_t       cfg_q;
  ctrl_cmd_t  cmd;
  dp_sts_t    sts;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_address       <= 8'd1;
      cfg_q.read_timeout_ticks  <= 16'd300;
      cfg_q.write_timeout_ticks <= 16'd1000;
      cfg_q.retry_count         <= 8'd2;
      cfg_q.frame_gap_ticks     <= 8'd20;
      cfg_q.read_pause_ticks    <= 8'd15;
      cfg_q.write_pause_ticks   <= 8'd100;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_SLAVE_ADDR:  cfg_q.slave_address       <= pwdata[7:0];
        REG_READ_TMO:    cfg_q.read_timeout_ticks  <= pwdata[15:0];
        REG_WRITE_TMO:   cfg_q.write_timeout_ticks <= pwdata[15:0];
        REG_RETRY:       cfg_q.retry_count         <= pwdata[7:0];
        REG_FRAME_GAP:   cfg_q.frame_gap_ticks     <= pwdata[7:0];
        REG_READ_PAUSE:  cfg_q.read_pause_ticks    <= pwdata[7:0];
        REG_WRITE_PAUSE: cfg_q.write_pause_ticks   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_SLAVE_ADDR:  prdata = {24'h0, cfg_q.slave_address};
      REG_READ_TMO:    prdata = {16'h0, cfg_q.read_timeout_ticks};
      REG_WRITE_TMO:   prdata = {16'h0, cfg_q.write_timeout_ticks};
      REG_RETRY:       prdata = {24'h0, cfg_q.retry_count};
      REG_FRAME_GAP:   prdata = {24'h0, cfg_q.frame_gap_ticks};
      REG_READ_PAUSE:  prdata = {24'h0, cfg_q.read_pause_ticks};
      REG_WRITE_PAUSE: prdata = {24'h0, cfg_q.write_pause_ticks};
      default:         prdata = 32'h0;
    endcase
  end

  mrsm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_if.valid),
    .in_ready_o(in_if.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mrsm_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .command_i         (in_if.command),
    .register_address_i(in_if.register_address),
    .write_value_i     (in_if.write_value),
    .received_byte_i   (in_if.received_byte),
    .out_ready_i       (out_if.ready),
    .out_valid_o       (out_if.valid),
    .result_kind_o     (out_if.result_kind),
    .transmit_byte_o   (out_if.transmit_byte),
    .last_of_run_o     (out_if.last_of_run),
    .status_o          (out_if.status),
    .read_data_o       (out_if.read_data)
  );

endmodule

>>> design/mrsm_ram.sv
`timescale 1ns / 1ps
module mrsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/mrsm_ctrl.sv
`timescale 1ns / 1ps
module mrsm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mrsm_pkg::dp_sts_t   sts_i,
  output mrsm_pkg::ctrl_cmd_t cmd_o
);
  import mrsm_pkg::*;

  typedef enum logic [6:0] {
    ST_WAIT     = 7'b0000001,
    ST_EVAL     = 7'b0000010,
    ST_SEND     = 7'b0000100,
    ST_CHKBEGIN = 7'b0001000,
    ST_CHECK    = 7'b0010000,
    ST_JUDGE    = 7'b0100000,
    ST_FIN      = 7'b1000000
  } state_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_RX    = 3'b010,
    PH_PAUSE = 3'b100
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   fail_q, fail_d;

  assign in_ready_o = (state_q == ST_WAIT);

  // next state and command decode
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    fail_d  = fail_q;
    cmd_o   = '0;
    cmd_o.fin_fail = fail_q;
    case (state_q)
      ST_WAIT: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_WAIT;
        case (sts_i.command)
          CMD_START_READ, CMD_START_WRITE: begin
            if (phase_q == PH_IDLE) begin
              cmd_o.start_load = 1'b1;
              cmd_o.send_init  = 1'b1;
              state_d = ST_SEND;
            end
          end
          CMD_RX_BYTE: begin
            if (phase_q == PH_RX && sts_i.count_lt_n) begin
              cmd_o.byte_store = 1'b1;
              if (sts_i.count_last) begin
                state_d = ST_CHKBEGIN;
              end
            end
          end
          CMD_TICK: begin
            if (phase_q == PH_RX) begin
              cmd_o.tick_rx = 1'b1;
              if (sts_i.rx_end) begin
                state_d = ST_CHKBEGIN;
              end
            end else if (phase_q == PH_PAUSE) begin
              cmd_o.pause_dec = 1'b1;
              if (sts_i.pause_zero) begin
                if (!sts_i.attempts_zero) begin
                  cmd_o.attempt_dec = 1'b1;
                  cmd_o.send_init   = 1'b1;
                  state_d = ST_SEND;
                end else begin
                  fail_d  = 1'b1;
                  phase_d = PH_IDLE;
                  state_d = ST_FIN;
                end
              end
            end
          end
          default: state_d = ST_WAIT;
        endcase
      end
      ST_SEND: begin
        if (sts_i.out_free) begin
          cmd_o.send_step = 1'b1;
          if (sts_i.send_last) begin
            cmd_o.rx_open = 1'b1;
            phase_d = PH_RX;
            if (sts_i.limit_zero) begin
              cmd_o.pause_begin = 1'b1;
              phase_d = PH_PAUSE;
            end
            state_d = ST_WAIT;
          end
        end
      end
      ST_CHKBEGIN: begin
        if (sts_i.short_reply) begin
          cmd_o.pause_begin = 1'b1;
          phase_d = PH_PAUSE;
          state_d = ST_WAIT;
        end else begin
          cmd_o.chk_start = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.chk_step = 1'b1;
        if (sts_i.chk_done) begin
          state_d = ST_JUDGE;
        end
      end
      ST_JUDGE: begin
        if (sts_i.reply_ok) begin
          fail_d  = 1'b0;
          phase_d = PH_IDLE;
          state_d = ST_FIN;
        end else begin
          cmd_o.pause_begin = 1'b1;
          phase_d = PH_PAUSE;
          state_d = ST_WAIT;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit_fin = 1'b1;
          state_d = ST_WAIT;
        end
      end
      default: state_d = ST_WAIT;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WAIT;
      phase_q <= PH_IDLE;
      fail_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      fail_q  <= fail_d;
    end
  end

endmodule

>>> design/mrsm_dp.sv
`timescale 1ns / 1ps
module mrsm_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mrsm_pkg::cfg_t      cfg_i,
  input  mrsm_pkg::ctrl_cmd_t cmd_i,
  output mrsm_pkg::dp_sts_t   sts_o,
  input  logic [1:0]          command_i,
  input  logic [15:0]         register_address_i,
  input  logic [15:0]         write_value_i,
  input  logic [7:0]          received_byte_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                result_kind_o,
  output logic [7:0]          transmit_byte_o,
  output logic                last_of_run_o,
  output logic                status_o,
  output logic [15:0]         read_data_o
);
  import mrsm_pkg::*;

  // latched input item
  logic [1:0]  it_cmd_q;
  logic [15:0] it_addr_q, it_val_q;
  logic [7:0]  it_byte_q;

  // transaction state
  logic             op_wr_q;
  logic [15:0]      h_addr_q, h_val_q;
  logic [7:0]       attempts_q;
  logic [15:0]      window_q;
  logic [7:0]       silence_q, pause_q;
  logic [RX_CW-1:0] count_q;
  logic [2:0]       k_q;
  logic [15:0]      crc_q;

  // reply check state
  logic [RX_CW-1:0] sweep_q, rdidx_q;
  logic             rdv_q;
  logic [7:0]       b0_q, b1_q, b3_q, b4_q, glo_q, ghi_q;
  logic [7:0]       rdata;

  // output register
  logic        out_vld_q, kind_q, last_q, stat_q;
  logic [7:0]  byte_q;
  logic [15:0] data_q;

  logic [15:0] limit, win_inc;
  logic [7:0]  sil_inc, pause_nxt, func, tx_byte;
  logic [7:0]  min_len;
  logic        out_free;

  assign limit     = op_wr_q ? cfg_i.write_timeout_ticks : cfg_i.read_timeout_ticks;
  assign func      = op_wr_q ? FUNC_WRITE : FUNC_READ;
  assign min_len   = op_wr_q ? WRITE_MIN_LEN : READ_MIN_LEN;
  assign win_inc   = (window_q == 16'hFFFF) ? window_q : window_q + 16'd1;
  assign sil_inc   = (silence_q == 8'hFF) ? silence_q : silence_q + 8'd1;
  assign pause_nxt = (pause_q != 8'd0) ? pause_q - 8'd1 : 8'd0;
  assign out_free  = !out_vld_q || out_ready_i;

  // request frame byte selection
  always_comb begin
    case (k_q)
      3'd0:    tx_byte = cfg_i.slave_address;
      3'd1:    tx_byte = func;
      3'd2:    tx_byte = h_addr_q[15:8];
      3'd3:    tx_byte = h_addr_q[7:0];
      3'd4:    tx_byte = op_wr_q ? h_val_q[15:8] : 8'h00;
      3'd5:    tx_byte = op_wr_q ? h_val_q[7:0] : 8'h01;
      3'd6:    tx_byte = crc_q[7:0];
      default: tx_byte = crc_q[15:8];
    endcase
  end

  // status to the controller
  always_comb begin
    sts_o.command       = it_cmd_q;
    sts_o.count_lt_n    = count_q < RX_CW'(RX_BUFFER_BYTES);
    sts_o.count_last    = count_q == RX_CW'(RX_BUFFER_BYTES - 1);
    sts_o.rx_end        = (win_inc >= limit) ||
                          ((count_q != '0) && (silence_q >= cfg_i.frame_gap_ticks));
    sts_o.pause_zero    = pause_nxt == 8'd0;
    sts_o.attempts_zero = attempts_q == 8'd0;
    sts_o.limit_zero    = limit == 16'd0;
    sts_o.send_last     = k_q == 3'd7;
    sts_o.short_reply   = {{(9 - RX_CW){1'b0}}, count_q} < {1'b0, min_len};
    sts_o.chk_done      = rdv_q && (rdidx_q == count_q - RX_CW'(1));
    sts_o.reply_ok      = (b0_q == cfg_i.slave_address) && (b1_q == func) &&
                          (crc_q == {ghi_q, glo_q});
    sts_o.out_free      = out_free;
  end

  // reply buffer
  mrsm_ram #(
    .WIDTH(8),
    .DEPTH(RX_BUFFER_BYTES)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (cmd_i.byte_store),
    .waddr_i(count_q[RX_AW-1:0]),
    .wdata_i(it_byte_q),
    .raddr_i(sweep_q[RX_AW-1:0]),
    .rdata_o(rdata)
  );

  // item, counters, crc and capture registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_wr_q    <= 1'b0;
      attempts_q <= '0;
      window_q   <= '0;
      silence_q  <= '0;
      pause_q    <= '0;
      count_q    <= '0;
      k_q        <= '0;
      sweep_q    <= '0;
      rdv_q      <= 1'b0;
    end else begin
      if (cmd_i.start_load) begin
        op_wr_q    <= it_cmd_q == CMD_START_WRITE;
        attempts_q <= cfg_i.retry_count;
      end
      if (cmd_i.attempt_dec) attempts_q <= attempts_q - 8'd1;
      if (cmd_i.send_init) k_q <= '0;
      if (cmd_i.send_step) k_q <= k_q + 3'd1;
      if (cmd_i.rx_open) begin
        count_q   <= '0;
        window_q  <= '0;
        silence_q <= '0;
      end
      if (cmd_i.byte_store) begin
        count_q   <= count_q + RX_CW'(1);
        silence_q <= '0;
      end
      if (cmd_i.tick_rx) begin
        window_q  <= win_inc;
        silence_q <= sil_inc;
      end
      if (cmd_i.pause_begin) begin
        pause_q <= op_wr_q ? cfg_i.write_pause_ticks : cfg_i.read_pause_ticks;
      end
      if (cmd_i.pause_dec) pause_q <= pause_nxt;
      if (cmd_i.chk_start) begin
        sweep_q <= '0;
        rdv_q   <= 1'b0;
      end else if (cmd_i.chk_step) begin
        if (sweep_q < count_q) begin
          sweep_q <= sweep_q + RX_CW'(1);
          rdv_q   <= 1'b1;
        end else begin
          rdv_q <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      it_cmd_q  <= command_i;
      it_addr_q <= register_address_i;
      it_val_q  <= write_value_i;
      it_byte_q <= received_byte_i;
    end
    if (cmd_i.start_load) begin
      h_addr_q <= it_addr_q;
      h_val_q  <= (it_cmd_q == CMD_START_WRITE) ? it_val_q : 16'h0000;
    end
    if (cmd_i.chk_step) rdidx_q <= sweep_q;
    // crc over the request, then over the reply
    if (cmd_i.send_init || cmd_i.chk_start) begin
      crc_q <= CRC_INIT;
    end else if (cmd_i.send_step && k_q < 3'd6) begin
      crc_q <= crc_byte(crc_q, tx_byte);
    end else if (cmd_i.chk_step && rdv_q && rdidx_q < count_q - RX_CW'(2)) begin
      crc_q <= crc_byte(crc_q, rdata);
    end
    // capture header, data and received crc
    if (cmd_i.chk_step && rdv_q) begin
      if (rdidx_q == RX_CW'(0)) b0_q <= rdata;
      if (rdidx_q == RX_CW'(1)) b1_q <= rdata;
      if (rdidx_q == RX_CW'(3)) b3_q <= rdata;
      if (rdidx_q == RX_CW'(4)) b4_q <= rdata;
      if (rdidx_q == count_q - RX_CW'(2)) glo_q <= rdata;
      if (rdidx_q == count_q - RX_CW'(1)) ghi_q <= rdata;
    end
  end

  // output register, parts result side from the work
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.send_step || cmd_i.emit_fin) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.send_step) begin
      kind_q <= 1'b0;
      byte_q <= tx_byte;
      last_q <= k_q == 3'd7;
      stat_q <= 1'b0;
      data_q <= 16'h0000;
    end else if (cmd_i.emit_fin) begin
      kind_q <= 1'b1;
      byte_q <= 8'h00;
      last_q <= 1'b1;
      stat_q <= cmd_i.fin_fail;
      data_q <= (cmd_i.fin_fail || op_wr_q) ? 16'h0000 : {b3_q, b4_q};
    end
  end

  assign out_valid_o     = out_vld_q;
  assign result_kind_o   = kind_q;
  assign transmit_byte_o = byte_q;
  assign last_of_run_o   = last_q;
  assign status_o        = stat_q;
  assign read_data_o     = data_q;

endmodule

>>> verif/tb_modbus_rtu_single_register_master_top.sv
`timescale 1ns / 1ps
module tb_modbus_rtu_single_register_master_top;
  import mrsm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 60;
  localparam int ITEM_TARGET = 170;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx;
    logic        last;
    logic        status;
    logic [15:0] data;
  } master_result_t;

  typedef enum logic [1:0] {LINK_IDLE, LINK_RECEIVE, LINK_PAUSE} link_phase_e;

  // flaws applied to a reply frame
  typedef enum int {
    FLAW_NONE, FLAW_ADDR, FLAW_FUNC, FLAW_CRC, FLAW_SHORT, FLAW_NOISE
  } reply_flaw_e;

  // tracks the master's protocol state and the results it must produce
  class modbus_master_scoreboard;
    cfg_t           cfg;
    link_phase_e    phase;
    bit             is_write;
    logic [15:0]    reg_addr;
    logic [15:0]    reg_value;
    logic [7:0]     tries_left;
    logic [15:0]    window;
    logic [7:0]     silence;
    logic [7:0]     pause_cnt;
    int unsigned    rx_count;
    logic [7:0]     rx_buf [RX_BUFFER_BYTES];
    master_result_t pending_results [$];
    master_result_t step_results [$];
    int             errors;
    int unsigned    items;

    function new();
      cfg.slave_address       = 8'd1;
      cfg.read_timeout_ticks  = 16'd300;
      cfg.write_timeout_ticks = 16'd1000;
      cfg.retry_count         = 8'd2;
      cfg.frame_gap_ticks     = 8'd20;
      cfg.read_pause_ticks    = 8'd15;
      cfg.write_pause_ticks   = 8'd100;
      phase = LINK_IDLE;
      is_write = 0;
      reg_addr = '0;
      reg_value = '0;
      tries_left = '0;
      window = '0;
      silence = '0;
      pause_cnt = '0;
      rx_count = 0;
      errors = 0;
      items = 0;
    endfunction

    function logic [15:0] frame_crc(input logic [7:0] msg [$], input int n);
      logic [15:0] c;
      c = 16'hFFFF;
      for (int k = 0; k < n; k++) begin
        c = c ^ {8'h00, msg[k]};
        for (int b = 0; b < 8; b++) begin
          c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
      end
      return c;
    endfunction

    function void push_result(input logic kind, input logic [7:0] tx, input logic status,
                              input logic [15:0] data);
      master_result_t r;
      r.kind = kind;
      r.tx = tx;
      r.last = 1'b0;
      r.status = status;
      r.data = data;
      step_results.push_back(r);
    endfunction

    function void begin_pause();
      phase = LINK_PAUSE;
      pause_cnt = is_write ? cfg.write_pause_ticks : cfg.read_pause_ticks;
    endfunction

    function void send_request();
      logic [7:0]  f [$];
      logic [15:0] c;
      f.push_back(cfg.slave_address);
      f.push_back(is_write ? FUNC_WRITE : FUNC_READ);
      f.push_back(reg_addr[15:8]);
      f.push_back(reg_addr[7:0]);
      f.push_back(is_write ? reg_value[15:8] : 8'h00);
      f.push_back(is_write ? reg_value[7:0] : 8'h01);
      c = frame_crc(f, 6);
      f.push_back(c[7:0]);
      f.push_back(c[15:8]);
      foreach (f[k]) push_result(1'b0, f[k], 1'b0, 16'h0000);
      rx_count = 0;
      window = '0;
      silence = '0;
      phase = LINK_RECEIVE;
      if ((is_write ? cfg.write_timeout_ticks : cfg.read_timeout_ticks) == 16'd0) begin
        begin_pause();
      end
    endfunction

    function void end_reply();
      logic [7:0]  msg [$];
      logic [15:0] got;
      bit          ok;
      int unsigned need;
      ok = 0;
      need = is_write ? 8 : 7;
      for (int k = 0; k < rx_count; k++) msg.push_back(rx_buf[k]);
      if (rx_count >= need && rx_buf[0] == cfg.slave_address &&
          rx_buf[1] == (is_write ? FUNC_WRITE : FUNC_READ)) begin
        got = {rx_buf[rx_count-1], rx_buf[rx_count-2]};
        ok = (frame_crc(msg, rx_count - 2) == got);
      end
      if (ok) begin
        push_result(1'b1, 8'h00, 1'b0, is_write ? 16'h0000 : {rx_buf[3], rx_buf[4]});
        phase = LINK_IDLE;
      end else begin
        begin_pause();
      end
    endfunction

    // work out the results of one accepted input transaction
    function void note_input(input logic [1:0] cmd, input logic [15:0] ra,
                             input logic [15:0] wv, input logic [7:0] rb);
      logic [15:0] limit;
      bit          gap_out;
      step_results.delete();
      items++;
      case (cmd)
        CMD_START_READ, CMD_START_WRITE: begin
          if (phase == LINK_IDLE) begin
            is_write = (cmd == CMD_START_WRITE);
            reg_addr = ra;
            reg_value = is_write ? wv : 16'h0000;
            tries_left = cfg.retry_count;
            send_request();
          end
        end
        CMD_RX_BYTE: begin
          if (phase == LINK_RECEIVE && rx_count < RX_BUFFER_BYTES) begin
            rx_buf[rx_count] = rb;
            rx_count++;
            silence = '0;
            if (rx_count >= RX_BUFFER_BYTES) end_reply();
          end
        end
        default: begin
          if (phase == LINK_RECEIVE) begin
            limit = is_write ? cfg.write_timeout_ticks : cfg.read_timeout_ticks;
            gap_out = (rx_count > 0) && (silence >= cfg.frame_gap_ticks);
            if (window != 16'hFFFF) window++;
            if (silence != 8'hFF) silence++;
            if (window >= limit || gap_out) end_reply();
          end else if (phase == LINK_PAUSE) begin
            if (pause_cnt > 0) pause_cnt--;
            if (pause_cnt == 0) begin
              if (tries_left > 0) begin
                tries_left--;
                send_request();
              end else begin
                push_result(1'b1, 8'h00, 1'b1, 16'h0000);
                phase = LINK_IDLE;
              end
            end
          end
        end
      endcase
      if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    endfunction

    // compare one accepted result transaction with the oldest expectation
    function void check_result(input master_result_t got);
      master_result_t exp;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d byte %0h", got.kind, got.tx);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.kind !== exp.kind) begin
        $error("result_kind: expected %0d, got %0d", exp.kind, got.kind);
        errors++;
      end
      if (got.tx !== exp.tx) begin
        $error("transmit_byte: expected %0h, got %0h", exp.tx, got.tx);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last_of_run: expected %0d, got %0d", exp.last, got.last);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.data !== exp.data) begin
        $error("read_data: expected %0h, got %0h", exp.data, got.data);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  int unsigned         cycle_count;
  bit                  no_idle;
  bit                  hold_request;
  modbus_master_scoreboard sb;

  mrsm_in_if  in_if ();
  mrsm_out_if out_if ();

  modbus_rtu_single_register_master_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if.sink),
    .out_if  (out_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    master_result_t r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      r.kind = out_if.result_kind;
      r.tx = out_if.transmit_byte;
      r.last = out_if.last_of_run;
      r.status = out_if.status;
      r.data = out_if.read_data;
      sb.check_result(r);
    end
  end

  // mostly short gaps, a few long ones, none in burst stretches
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result receiver with random stalls and one long hold-off on request
  initial begin
    int n;
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_if.ready <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [15:0] ra,
                           input logic [15:0] wv, input logic [7:0] rb);
    int n;
    n = idle_len();
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_if.command <= cmd;
    in_if.register_address <= ra;
    in_if.write_value <= wv;
    in_if.received_byte <= rb;
    in_if.valid <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(cmd, ra, wv, rb);
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(CMD_RX_BYTE, 16'($urandom), 16'($urandom), b);
  endtask

  task automatic send_start(input logic [1:0] cmd, input logic [15:0] ra, input logic [15:0] wv);
    send_item(cmd, ra, wv, 8'($urandom));
  endtask

  // reply frame for the request in flight, with an optional flaw
  task automatic send_reply(input reply_flaw_e flaw, input int total_len);
    logic [7:0]  f [$];
    logic [15:0] c;
    int          body;
    f.push_back(sb.cfg.slave_address);
    if (sb.is_write) begin
      f.push_back(FUNC_WRITE);
      f.push_back(sb.reg_addr[15:8]);
      f.push_back(sb.reg_addr[7:0]);
      f.push_back(sb.reg_value[15:8]);
      f.push_back(sb.reg_value[7:0]);
    end else begin
      f.push_back(FUNC_READ);
      f.push_back(8'h02);
      f.push_back(8'($urandom));
      f.push_back(8'($urandom));
    end
    body = (total_len > f.size() + 2) ? total_len - 2 : f.size();
    while (f.size() < body) f.push_back(8'($urandom));
    c = sb.frame_crc(f, f.size());
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
    case (flaw)
      FLAW_ADDR:  f[0] = f[0] ^ 8'($urandom_range(1, 255));
      FLAW_FUNC:  f[1] = f[1] ^ 8'($urandom_range(1, 255));
      FLAW_CRC:   f[$urandom_range(0, f.size()-1)] ^= 8'(1 << $urandom_range(0, 7));
      FLAW_SHORT: repeat ($urandom_range(1, 4)) void'(f.pop_back());
      FLAW_NOISE: foreach (f[k]) f[k] = 8'($urandom);
      default: ;
    endcase
    foreach (f[k]) send_byte(f[k]);
  endtask

  // tick until the master is back in idle
  task automatic tick_to_idle();
    int n;
    n = 0;
    while (sb.phase != LINK_IDLE && n < 3000) begin
      send_tick();
      n++;
    end
  endtask

  // let every expected result arrive and the block go quiet
  task automatic settle();
    @(posedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SLAVE_ADDR:  sb.cfg.slave_address = value[7:0];
      REG_READ_TMO:    sb.cfg.read_timeout_ticks = value[15:0];
      REG_WRITE_TMO:   sb.cfg.write_timeout_ticks = value[15:0];
      REG_RETRY:       sb.cfg.retry_count = value[7:0];
      REG_FRAME_GAP:   sb.cfg.frame_gap_ticks = value[7:0];
      REG_READ_PAUSE:  sb.cfg.read_pause_ticks = value[7:0];
      REG_WRITE_PAUSE: sb.cfg.write_pause_ticks = value[7:0];
      default: ;
    endcase
  endtask

  // full register set, written only with the master idle and drained
  task automatic load_config(input logic [7:0] slave, input logic [15:0] rd_tmo,
                             input logic [15:0] wr_tmo, input logic [7:0] retry,
                             input logic [7:0] gap, input logic [7:0] rd_pause,
                             input logic [7:0] wr_pause);
    tick_to_idle();
    settle();
    apb_write(REG_SLAVE_ADDR, 32'(slave));
    apb_write(REG_READ_TMO, 32'(rd_tmo));
    apb_write(REG_WRITE_TMO, 32'(wr_tmo));
    apb_write(REG_RETRY, 32'(retry));
    apb_write(REG_FRAME_GAP, 32'(gap));
    apb_write(REG_READ_PAUSE, 32'(rd_pause));
    apb_write(REG_WRITE_PAUSE, 32'(wr_pause));
  endtask

  // one request with a random reply scenario
  task automatic random_exchange();
    logic [1:0] op;
    int         pick;
    op = $urandom_range(0, 1) ? CMD_START_WRITE : CMD_START_READ;
    send_start(op, 16'($urandom), 16'($urandom));
    while (sb.phase != LINK_IDLE) begin
      pick = $urandom_range(0, 99);
      if (sb.phase == LINK_RECEIVE && pick < 45) begin
        send_reply(FLAW_NONE, ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : 0);
      end else if (sb.phase == LINK_RECEIVE && pick < 65) begin
        send_reply(reply_flaw_e'($urandom_range(1, 5)), 0);
      end else if (pick < 72) begin
        send_start(2'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
      end else if (pick < 78) begin
        send_byte(8'($urandom));
      end
      repeat ($urandom_range(1, 6)) begin
        if (sb.phase != LINK_IDLE) send_tick();
      end
    end
  endtask

  initial begin
    bit held;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.command = CMD_TICK;
    in_if.register_address = '0;
    in_if.write_value = '0;
    in_if.received_byte = '0;
    out_if.ready = 1'b0;
    cycle_count = 0;
    no_idle = 0;
    hold_request = 0;
    held = 0;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: idle tick and byte, good read and write, start while busy
    send_tick();
    send_byte(8'hFF);
    send_start(CMD_START_READ, 16'h0000, 16'hFFFF);
    send_start(CMD_START_WRITE, 16'hFFFF, 16'h0000);
    send_reply(FLAW_NONE, 0);
    tick_to_idle();
    send_start(CMD_START_WRITE, 16'hFFFF, 16'hFFFF);
    send_reply(FLAW_NONE, 0);
    tick_to_idle();

    // small windows: bad frames, timeout, gap
    load_config(8'hFF, 16'd5, 16'd7, 8'd1, 8'd2, 8'd0, 8'd3);
    send_start(CMD_START_READ, 16'h1234, 16'h0000);
    send_reply(FLAW_CRC, 0);
    send_tick();
    send_tick();
    send_tick();
    send_byte(8'h55);
    send_reply(FLAW_ADDR, 0);
    tick_to_idle();
    send_start(CMD_START_WRITE, 16'h00FF, 16'hFF00);
    send_reply(FLAW_SHORT, 0);
    tick_to_idle();

    // zero timeouts, retries and pauses
    load_config(8'h00, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_start(CMD_START_READ, 16'h8001, 16'h0000);
    send_byte(8'h00);
    send_tick();
    send_start(CMD_START_WRITE, 16'h7FFE, 16'h8000);
    send_tick();

    // largest settings, replies ended by a full buffer
    load_config(8'h80, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_start(CMD_START_READ, 16'h0001, 16'h0000);
    send_reply(FLAW_NONE, RX_BUFFER_BYTES);
    send_start(CMD_START_WRITE, 16'hFFFE, 16'h7FFF);
    send_reply(FLAW_NONE, RX_BUFFER_BYTES);

    // random settings and exchanges up to the item budget
    while (sb.items < ITEM_TARGET) begin
      load_config(8'($urandom), 16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                  8'($urandom_range(0, 3)), 8'($urandom_range(0, 4)),
                  8'($urandom_range(0, 5)), 8'($urandom_range(0, 5)));
      for (int k = 0; k < 6 && sb.items < ITEM_TARGET; k++) begin
        no_idle = ($urandom_range(0, 3) == 0);
        if (!held) begin
          // long receiver hold-off while requests keep coming
          held = 1;
          hold_request = 1;
          wait (hold_request == 0);
          repeat (4) send_start(CMD_START_READ, 16'($urandom), 16'($urandom));
          repeat (10) send_tick();
        end
        random_exchange();
        if ($urandom_range(0, 2) == 0) begin
          send_item(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 8'($urandom));
        end
      end
      no_idle = 0;
    end

    tick_to_idle();
    settle();
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
